### rtl/core/jwn_pkg.sv
package jwn_pkg;

  localparam int unsigned CP_W = 21;

  // Number of result words the queue can hold; two are needed for a single item.
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CP_W-1:0] FW_ASCII_FIRST  = 21'h00FF01;
  localparam logic [CP_W-1:0] FW_ASCII_LAST   = 21'h00FF5E;
  localparam logic [CP_W-1:0] ASCII_BANG      = 21'h000021;
  localparam logic [CP_W-1:0] IDEO_SPACE      = 21'h003000;
  localparam logic [CP_W-1:0] ASCII_SPACE     = 21'h000020;
  localparam logic [CP_W-1:0] HALF_KANA_FIRST = 21'h00FF66;
  localparam logic [CP_W-1:0] HALF_KANA_LAST  = 21'h00FF9D;
  localparam logic [CP_W-1:0] MINUS_SIGN      = 21'h002212;
  localparam logic [CP_W-1:0] HYPHEN          = 21'h002010;
  localparam logic [CP_W-1:0] NB_HYPHEN       = 21'h002011;
  localparam logic [CP_W-1:0] EN_DASH         = 21'h002013;
  localparam logic [CP_W-1:0] EM_DASH         = 21'h002014;
  localparam logic [CP_W-1:0] ASCII_DASH      = 21'h00002D;
  localparam logic [CP_W-1:0] HALF_COMMA      = 21'h00FF64;
  localparam logic [CP_W-1:0] IDEO_COMMA      = 21'h003001;
  localparam logic [CP_W-1:0] HALF_PERIOD     = 21'h00FF61;
  localparam logic [CP_W-1:0] IDEO_PERIOD     = 21'h003002;
  localparam logic [CP_W-1:0] LEFT_QUOTE      = 21'h002018;
  localparam logic [CP_W-1:0] RIGHT_QUOTE     = 21'h002019;
  localparam logic [CP_W-1:0] APOSTROPHE      = 21'h000027;

  localparam logic [CP_W-1:0] VOICED_HALF     = 21'h00FF9E;
  localparam logic [CP_W-1:0] VOICED_COMB     = 21'h003099;
  localparam logic [CP_W-1:0] VOICED_SPACING  = 21'h00309B;
  localparam logic [CP_W-1:0] SEMI_HALF       = 21'h00FF9F;
  localparam logic [CP_W-1:0] SEMI_COMB       = 21'h00309A;
  localparam logic [CP_W-1:0] SEMI_SPACING    = 21'h00309C;

  localparam logic [CP_W-1:0] KANA_U          = 21'h0030A6;
  localparam logic [CP_W-1:0] KANA_VU         = 21'h0030F4;
  localparam logic [CP_W-1:0] KANA_KA         = 21'h0030AB;
  localparam logic [CP_W-1:0] KANA_CHI        = 21'h0030C1;
  localparam logic [CP_W-1:0] KANA_TSU        = 21'h0030C4;
  localparam logic [CP_W-1:0] KANA_TO         = 21'h0030C8;
  localparam logic [CP_W-1:0] KANA_HA         = 21'h0030CF;
  localparam logic [CP_W-1:0] KANA_HI         = 21'h0030D2;
  localparam logic [CP_W-1:0] KANA_FU         = 21'h0030D5;
  localparam logic [CP_W-1:0] KANA_HE         = 21'h0030D8;
  localparam logic [CP_W-1:0] KANA_HO         = 21'h0030DB;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            last_of_text;
    logic            last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [15:0] half_kana(input logic [5:0] idx);
    logic [15:0] r;
    case (idx)
      6'd0:  r = 16'h30F2;  6'd1:  r = 16'h30A1;  6'd2:  r = 16'h30A3;  6'd3:  r = 16'h30A5;
      6'd4:  r = 16'h30A7;  6'd5:  r = 16'h30A9;  6'd6:  r = 16'h30E3;  6'd7:  r = 16'h30E5;
      6'd8:  r = 16'h30E7;  6'd9:  r = 16'h30C3;  6'd10: r = 16'h30FC;  6'd11: r = 16'h30A2;
      6'd12: r = 16'h30A4;  6'd13: r = 16'h30A6;  6'd14: r = 16'h30A8;  6'd15: r = 16'h30AA;
      6'd16: r = 16'h30AB;  6'd17: r = 16'h30AD;  6'd18: r = 16'h30AF;  6'd19: r = 16'h30B1;
      6'd20: r = 16'h30B3;  6'd21: r = 16'h30B5;  6'd22: r = 16'h30B7;  6'd23: r = 16'h30B9;
      6'd24: r = 16'h30BB;  6'd25: r = 16'h30BD;  6'd26: r = 16'h30BF;  6'd27: r = 16'h30C1;
      6'd28: r = 16'h30C4;  6'd29: r = 16'h30C6;  6'd30: r = 16'h30C8;  6'd31: r = 16'h30CA;
      6'd32: r = 16'h30CB;  6'd33: r = 16'h30CC;  6'd34: r = 16'h30CD;  6'd35: r = 16'h30CE;
      6'd36: r = 16'h30CF;  6'd37: r = 16'h30D2;  6'd38: r = 16'h30D5;  6'd39: r = 16'h30D8;
      6'd40: r = 16'h30DB;  6'd41: r = 16'h30DE;  6'd42: r = 16'h30DF;  6'd43: r = 16'h30E0;
      6'd44: r = 16'h30E1;  6'd45: r = 16'h30E2;  6'd46: r = 16'h30E4;  6'd47: r = 16'h30E6;
      6'd48: r = 16'h30E8;  6'd49: r = 16'h30E9;  6'd50: r = 16'h30EA;  6'd51: r = 16'h30EB;
      6'd52: r = 16'h30EC;  6'd53: r = 16'h30ED;  6'd54: r = 16'h30EF;  6'd55: r = 16'h30F3;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  function automatic logic [CP_W-1:0] map_char(input logic [CP_W-1:0] c);
    logic [CP_W-1:0] r;
    logic [CP_W-1:0] off;
    off = c - HALF_KANA_FIRST;
    if (c >= FW_ASCII_FIRST && c <= FW_ASCII_LAST) begin
      r = c - FW_ASCII_FIRST + ASCII_BANG;
    end else if (c == IDEO_SPACE) begin
      r = ASCII_SPACE;
    end else if (c >= HALF_KANA_FIRST && c <= HALF_KANA_LAST) begin
      r = {5'd0, half_kana(off[5:0])};
    end else if (c == MINUS_SIGN || c == HYPHEN || c == NB_HYPHEN || c == EN_DASH ||
                 c == EM_DASH) begin
      r = ASCII_DASH;
    end else if (c == HALF_COMMA) begin
      r = IDEO_COMMA;
    end else if (c == HALF_PERIOD) begin
      r = IDEO_PERIOD;
    end else if (c == LEFT_QUOTE || c == RIGHT_QUOTE) begin
      r = APOSTROPHE;
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic logic is_ha_row(input logic [CP_W-1:0] c);
    return c == KANA_HA || c == KANA_HI || c == KANA_FU || c == KANA_HE || c == KANA_HO;
  endfunction

  function automatic logic [CP_W-1:0] apply_mark(input logic [CP_W-1:0] c, input logic semi);
    logic [CP_W-1:0] r;
    r = c;
    if (semi) begin
      if (is_ha_row(c)) r = c + 21'd2;
    end else if (c == KANA_U) begin
      r = KANA_VU;
    end else if (c >= KANA_KA && c <= KANA_CHI && c[0]) begin
      // KA is odd, so the voiceable members of that run are the odd code points.
      r = c + 21'd1;
    end else if (c >= KANA_TSU && c <= KANA_TO && !c[0]) begin
      r = c + 21'd1;
    end else if (is_ha_row(c)) begin
      r = c + 21'd1;
    end
    return r;
  endfunction

endpackage

### rtl/core/jwn_char_if.sv
interface jwn_char_if
  import jwn_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            end_of_text;

  modport source (output valid, output code_point, output end_of_text, input ready);
  modport sink (input valid, input code_point, input end_of_text, output ready);
endinterface

### rtl/core/jwn_norm_if.sv
interface jwn_norm_if
  import jwn_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] out_code_point;
  logic            last_of_text;
  logic            last_of_run;

  modport source (output valid, output out_code_point, output last_of_text,
                  output last_of_run, input ready);
  modport sink (input valid, input out_code_point, input last_of_text,
                input last_of_run, output ready);
endinterface

### rtl/core/japanese_width_normalizer.sv
// Channel     Direction  Payload
// chars       in         code_point[20:0], end_of_text
// normalized  out        out_code_point[20:0], last_of_text, last_of_run
//
// One character word is taken per cycle. It is registered, then mapped and merged with the
// held character, and its zero to two result words enter a four-word queue whose head
// drives the output. The input stalls only while the queue cannot take two more words.
// Synchronous reset empties the queue and clears the held character.
module japanese_width_normalizer
  import jwn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  jwn_char_if.sink   chars,
  jwn_norm_if.source normalized
);

  logic            stg_valid;
  logic [CP_W-1:0] stg_cp;
  logic            stg_eot;
  logic [CP_W-1:0] held_char;
  logic            held_valid;

  logic            room;
  logic            fire;
  logic            voiced_mark;
  logic            semi_mark;
  logic            combine;
  logic            emit_prev;
  logic [CP_W-1:0] new_held;
  result_t         prev_res;
  result_t         final_res;
  push_t           push;

  assign fire        = stg_valid && room;
  assign chars.ready = !stg_valid || fire;

  assign voiced_mark = stg_cp == VOICED_HALF || stg_cp == VOICED_COMB ||
                       stg_cp == VOICED_SPACING;
  assign semi_mark   = stg_cp == SEMI_HALF || stg_cp == SEMI_COMB || stg_cp == SEMI_SPACING;
  // A mark with nothing held is treated as an ordinary character.
  assign combine     = (voiced_mark || semi_mark) && held_valid;
  assign emit_prev   = !combine && held_valid;
  assign new_held    = combine ? apply_mark(held_char, semi_mark) : map_char(stg_cp);

  always_comb begin
    prev_res  = '{cp: held_char, last_of_text: 1'b0, last_of_run: !stg_eot};
    final_res = '{cp: new_held, last_of_text: 1'b1, last_of_run: 1'b1};
    push      = '{count: 2'd0, first: prev_res, second: final_res};
    if (fire) begin
      push.count = 2'({1'b0, emit_prev} + {1'b0, stg_eot});
      if (!emit_prev) begin
        push.first = final_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid  <= 1'b0;
      held_char  <= '0;
      held_valid <= 1'b0;
    end else begin
      if (chars.valid && chars.ready) begin
        stg_valid <= 1'b1;
      end else if (fire) begin
        stg_valid <= 1'b0;
      end
      if (fire) begin
        held_char  <= stg_eot ? '0 : new_held;
        held_valid <= !stg_eot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      stg_cp  <= chars.code_point;
      stg_eot <= chars.end_of_text;
    end
  end

  jwn_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .normalized (normalized)
  );

endmodule

### rtl/core/jwn_result_queue.sv
module jwn_result_queue
  import jwn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  push_t       push,
  output logic        room,
  jwn_norm_if.source  normalized
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                pop;

  assign pop  = normalized.valid && normalized.ready;
  // Room for the two words one item may produce.
  assign room = count <= CNT_W'(QUEUE_DEPTH - 2);

  assign normalized.valid          = count != '0;
  assign normalized.out_code_point = entries[rd_ptr].cp;
  assign normalized.last_of_text   = entries[rd_ptr].last_of_text;
  assign normalized.last_of_run    = entries[rd_ptr].last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

endmodule

### rtl/core/jwn_checker.sv
module jwn_checker
  import jwn_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CP_W-1:0] out_cp,
  input logic            out_lot,
  input logic            out_lor
);

  // Nothing can be ready to leave in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word shown straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_cp) && $stable(out_lot) &&
                                $stable(out_lor))
    else $error("stalled result word changed");

  // The end of a text always closes the run of its item.
  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_lot |-> out_lor)
    else $error("last_of_text without last_of_run");

  // Full-width ASCII and half-width katakana never survive the mapping.
  a_no_wide_forms: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !((out_cp >= FW_ASCII_FIRST && out_cp <= FW_ASCII_LAST) ||
                    (out_cp >= HALF_KANA_FIRST && out_cp <= HALF_KANA_LAST)))
    else $error("unmapped full-width or half-width form on output");

endmodule

bind japanese_width_normalizer jwn_checker u_jwn_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (normalized.valid),
  .out_ready (normalized.ready),
  .out_cp    (normalized.out_code_point),
  .out_lot   (normalized.last_of_text),
  .out_lor   (normalized.last_of_run)
);
